>>> sv/qjt_pkg.sv
package qjt_pkg;

	localparam int JOINTS    = 15;
	localparam int POS_WIDTH = 16;
	localparam int JIDX_W    = 4;
	localparam int DUR_W     = 16;
	localparam int S_W       = 17;

	localparam logic [DUR_W-1:0] DUR_RESET = 16'd500;
	localparam logic [S_W-1:0]   ONE_Q16   = 17'h10000;
	localparam int               HALF_Q16  = 32768;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic [JIDX_W-1:0]           jidx_t;
	typedef logic [DUR_W-1:0]            dur_t;
	typedef logic [S_W-1:0]              s_t;

	typedef struct packed {
		logic  en;
		jidx_t addr;
		pos_t  start;
		pos_t  target;
	} mem_wr_t;

	typedef struct packed {
		pos_t start;
		pos_t target;
	} mem_rd_t;

endpackage

>>> sv/qjt_pos_mem.sv
module qjt_pos_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  qjt_pkg::mem_wr_t wr,
	input  qjt_pkg::jidx_t   rd_addr,
	output qjt_pkg::mem_rd_t rd_data
);
	import qjt_pkg::*;

	logic [2*POS_WIDTH-1:0] mem [JOINTS];
	logic [JOINTS-1:0]      vld_q;
	logic [2*POS_WIDTH-1:0] rd_word_q;
	logic                   rd_vld_q;

	// Entries never written since reset read as zero through their valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.start, wr.target};
		end
		rd_word_q <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	always_comb begin
		if (rd_vld_q) begin
			rd_data.start  = pos_t'(rd_word_q[2*POS_WIDTH-1:POS_WIDTH]);
			rd_data.target = pos_t'(rd_word_q[POS_WIDTH-1:0]);
		end else begin
			rd_data.start  = '0;
			rd_data.target = '0;
		end
	end

endmodule

>>> sv/qjt_div.sv
module qjt_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  qjt_pkg::dur_t n,
	input  qjt_pkg::dur_t dur,
	output logic          done,
	output qjt_pkg::s_t   s
);
	import qjt_pkg::*;

	typedef enum logic [1:0] {
		DV_IDLE = 2'b01,
		DV_RUN  = 2'b10
	} dv_state_t;

	dv_state_t  state_q;
	logic [4:0] cnt_q;
	dur_t       rem_q;
	dur_t       dur_q;
	s_t         quo_q;
	logic       done_q;
	logic [DUR_W:0] rem_shift;
	logic           fits;

	assign rem_shift = {rem_q, 1'b0};
	assign fits      = rem_shift >= {1'b0, dur_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						if (n == dur) begin
							done_q <= 1'b1;
						end else begin
							cnt_q   <= 5'(DUR_W);
							state_q <= DV_RUN;
						end
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	// Restoring division of n * 2^16 by dur, one quotient bit per cycle; n equal to dur gives 1.0 directly.
	// With n below dur the remainder always stays below dur.
	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					rem_q <= n;
					dur_q <= dur;
					quo_q <= (n == dur) ? ONE_Q16 : '0;
				end
			end
			DV_RUN: begin
				if (fits) begin
					rem_q <= DUR_W'(rem_shift - {1'b0, dur_q});
				end else begin
					rem_q <= rem_shift[DUR_W-1:0];
				end
				quo_q <= {quo_q[S_W-2:0], fits};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign s    = quo_q;

endmodule

>>> sv/qjt_blend.sv
module qjt_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  qjt_pkg::s_t s,
	output logic        done,
	output qjt_pkg::s_t h
);
	import qjt_pkg::*;

	localparam int PW   = S_W + 3;
	localparam int PRDW = PW + S_W;

	typedef enum logic [6:0] {
		BL_IDLE = 7'b0000001,
		BL_M1   = 7'b0000010,
		BL_R1   = 7'b0000100,
		BL_M2   = 7'b0001000,
		BL_R2   = 7'b0010000,
		BL_M3   = 7'b0100000,
		BL_R3   = 7'b1000000
	} bl_state_t;

	bl_state_t         state_q;
	logic              done_q;
	s_t                s_q;
	s_t                s2_q;
	s_t                s3_q;
	s_t                h_q;
	logic [PW-1:0]     p_q;
	logic [PRDW-1:0]   prod_q;
	logic [PW-1:0]     mul_a;
	s_t                mul_b;
	logic [PRDW-S_W:0] rounded;
	logic signed [PW+1:0] poly;

	// One multiplier serves the square, the cube and the final product.
	always_comb begin
		case (state_q)
			BL_M1:   begin mul_a = PW'(s_q);  mul_b = s_q;  end
			BL_M2:   begin mul_a = PW'(s2_q); mul_b = s_q;  end
			BL_M3:   begin mul_a = p_q;       mul_b = s3_q; end
			default: begin mul_a = '0;        mul_b = '0;   end
		endcase
	end

	assign rounded = (PRDW-S_W+1)'((prod_q + PRDW'(HALF_Q16)) >> 16);
	assign poly    = (PW+2)'(6) * $signed({2'b00, PW'(s2_q)})
		- (PW+2)'(15) * $signed({2'b00, PW'(s_q)})
		+ (PW+2)'(655360);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BL_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				BL_IDLE: if (start) state_q <= BL_M1;
				BL_M1:   state_q <= BL_R1;
				BL_R1:   state_q <= BL_M2;
				BL_M2:   state_q <= BL_R2;
				BL_R2:   state_q <= BL_M3;
				BL_M3:   state_q <= BL_R3;
				BL_R3: begin
					done_q  <= 1'b1;
					state_q <= BL_IDLE;
				end
				default: state_q <= BL_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BL_IDLE && start) begin
			s_q <= s;
		end
		if (state_q == BL_M1 || state_q == BL_M2 || state_q == BL_M3) begin
			prod_q <= PRDW'(mul_a * mul_b);
		end
		if (state_q == BL_R1) begin
			s2_q <= S_W'(rounded);
		end
		if (state_q == BL_R2) begin
			s3_q <= S_W'(rounded);
			p_q  <= poly[PW+1] ? '0 : PW'(poly);
		end
		if (state_q == BL_R3) begin
			h_q <= (rounded > (PRDW-S_W+1)'(ONE_Q16)) ? ONE_Q16 : S_W'(rounded);
		end
	end

	assign done = done_q;
	assign h    = h_q;

endmodule

>>> sv/quintic_joint_trajectory_top.sv
// A load transaction restarts time. A tick transaction runs the divider for s and
// the blend sequencer for h, then steps each joint through the position memory
// read, the joint multiplier and the output register (ST_RD, ST_MUL, ST_OUT), which
// waits while the output is stalled. No new transaction is taken until the last joint is out.
// Once the motion has ended the divider's run is skipped.
// Reset sets the duration to 500 and the tick count to zero; unwritten entries read as zero.
module quintic_joint_trajectory_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  qjt_pkg::jidx_t      joint_index,
	input  qjt_pkg::pos_t       start_position,
	input  qjt_pkg::pos_t       target_position,
	output logic                out_valid,
	input  logic                out_stall,
	output qjt_pkg::jidx_t      joint_out,
	output qjt_pkg::pos_t       command_position,
	output logic                last,
	output logic                done_res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  qjt_pkg::dur_t       cfg_data
);
	import qjt_pkg::*;

	localparam int PRODW = POS_WIDTH + 18;
	localparam int SUMW  = POS_WIDTH + 4;
	localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'((2 ** (POS_WIDTH - 1)) - 1);
	localparam logic signed [SUMW-1:0] SUM_MIN = -SUM_MAX - SUMW'(1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_BLEND = 6'b000100,
		ST_RD    = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_OUT   = 6'b100000
	} st_t;

	st_t     state_q;
	dur_t    dur_q;
	dur_t    tick_q;
	logic    done_q;
	s_t      h_q;
	jidx_t   jidx_q;
	logic    out_valid_q;
	jidx_t   joint_q;
	pos_t    cmd_q;
	logic    last_q;
	logic    done_res_q;

	logic signed [PRODW-1:0] prod_s1;
	pos_t                    start_s1;

	logic    in_acc;
	logic    tick_acc;
	dur_t    dur_eff;
	dur_t    n_eff;
	logic    div_done;
	s_t      div_s;
	logic    blend_done;
	s_t      blend_h;
	mem_wr_t mem_wr;
	mem_rd_t mem_rd;
	logic    out_free;
	logic    is_last;

	logic signed [POS_WIDTH:0]   diff;
	logic signed [PRODW:0]       rnd;
	logic signed [POS_WIDTH+2:0] term;
	logic signed [SUMW-1:0]      sum_w;
	pos_t                        sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign tick_acc  = in_acc && (op == OP_TICK);
	assign cfg_ready = 1'b1;

	assign dur_eff = (dur_q == '0) ? DUR_W'(1) : dur_q;
	assign n_eff   = (tick_q < dur_eff) ? tick_q : dur_eff;

	assign mem_wr.en     = in_acc && (op == OP_LOAD) && (joint_index < JIDX_W'(JOINTS));
	assign mem_wr.addr   = joint_index;
	assign mem_wr.start  = start_position;
	assign mem_wr.target = target_position;

	qjt_pos_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_addr (jidx_q),
		.rd_data (mem_rd)
	);

	qjt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tick_acc),
		.n      (n_eff),
		.dur    (dur_eff),
		.done   (div_done),
		.s      (div_s)
	);

	qjt_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIV && div_done),
		.s      (div_s),
		.done   (blend_done),
		.h      (blend_h)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign is_last  = (jidx_q == JIDX_W'(JOINTS - 1));

	assign diff = {mem_rd.target[POS_WIDTH-1], mem_rd.target}
		- {mem_rd.start[POS_WIDTH-1], mem_rd.start};

	// Arithmetic shift of the rounded product is the floor division by 2^16.
	assign rnd   = {prod_s1[PRODW-1], prod_s1} + (PRODW+1)'(HALF_Q16);
	assign term  = rnd[PRODW:16];
	assign sum_w = {{4{start_s1[POS_WIDTH-1]}}, start_s1} + {term[POS_WIDTH+2], term};

	always_comb begin
		if (sum_w > SUM_MAX) begin
			sat = pos_t'(SUM_MAX[POS_WIDTH-1:0]);
		end else if (sum_w < SUM_MIN) begin
			sat = pos_t'(SUM_MIN[POS_WIDTH-1:0]);
		end else begin
			sat = pos_t'(sum_w[POS_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dur_q       <= DUR_RESET;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
			jidx_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dur_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == OP_LOAD) begin
							tick_q <= '0;
						end else begin
							if (tick_q != '1) begin
								tick_q <= tick_q + DUR_W'(1);
							end
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					if (blend_done) begin
						jidx_q  <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							jidx_q  <= jidx_q + JIDX_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			done_q <= (tick_q >= dur_eff);
		end
		if (state_q == ST_BLEND && blend_done) begin
			h_q <= blend_h;
		end
		if (state_q == ST_MUL) begin
			prod_s1  <= PRODW'(diff * $signed({1'b0, h_q}));
			start_s1 <= mem_rd.start;
		end
		if (state_q == ST_OUT && out_free) begin
			joint_q    <= jidx_q;
			cmd_q      <= sat;
			last_q     <= is_last;
			done_res_q <= done_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign joint_out        = joint_q;
	assign command_position = cmd_q;
	assign last             = last_q;
	assign done_res         = done_res_q;

endmodule

>>> tb/sv/tb.sv
module tb;
	import qjt_pkg::*;

	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		jidx_t joint;
		pos_t  pos;
		logic  last;
		logic  done;
	} traj_result_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	logic   op;
	jidx_t  joint_index;
	pos_t   start_position;
	pos_t   target_position;
	logic   out_valid;
	logic   out_stall;
	jidx_t  joint_out;
	pos_t   command_position;
	logic   last;
	logic   done_res;
	logic   cfg_valid;
	logic   cfg_ready;
	dur_t   cfg_data;

	// Shadow copy of the trajectory state.
	pos_t   start_tab [JOINTS];
	pos_t   target_tab[JOINTS];
	int     tick_cnt;
	dur_t   duration;

	traj_result_t expected_q[$];
	int     fail_count;
	int     sink_hold;
	bit     quiet;

	quintic_joint_trajectory_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.joint_index      (joint_index),
		.start_position   (start_position),
		.target_position  (target_position),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.joint_out        (joint_out),
		.command_position (command_position),
		.last             (last),
		.done_res         (done_res),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Blend h(s) = 10s^3 - 15s^4 + 6s^5 in Q16, rounded at each product.
	function automatic longint blend_q16(input longint s);
		longint s2, s3, p, h;
		s2 = (s * s + HALF_Q16) >> 16;
		s3 = (s2 * s + HALF_Q16) >> 16;
		p = 6 * s2 - 15 * s + 10 * 65536;
		if (p < 0)
			p = 0;
		h = (p * s3 + HALF_Q16) >> 16;
		if (h > 65536)
			h = 65536;
		return h;
	endfunction

	// Updates the shadow state for one accepted transaction and queues the
	// commanded positions that a tick produces.
	function automatic void apply_item(input logic op_v, input jidx_t idx,
			input pos_t sp, input pos_t tp);
		longint dur, n, s, h, d, q;
		traj_result_t r;
		if (op_v == OP_LOAD) begin
			if (idx < JOINTS) begin
				start_tab[idx]  = sp;
				target_tab[idx] = tp;
			end
			tick_cnt = 0;
		end else begin
			dur = (duration == 0) ? 1 : longint'(duration);
			n = (tick_cnt < dur) ? tick_cnt : dur;
			s = (n << 16) / dur;
			h = blend_q16(s);
			for (int j = 0; j < JOINTS; j++) begin
				d = longint'(target_tab[j]) - longint'(start_tab[j]);
				q = longint'(start_tab[j]) + ((d * h + HALF_Q16) >>> 16);
				if (q > 32767)
					q = 32767;
				else if (q < -32768)
					q = -32768;
				r.joint = jidx_t'(j);
				r.pos   = pos_t'(q);
				r.last  = (j == JOINTS - 1);
				r.done  = (tick_cnt >= dur);
				expected_q.push_back(r);
			end
			if (tick_cnt < 65535)
				tick_cnt++;
		end
	endfunction

	function automatic jidx_t random_joint();
		if ($urandom_range(0, 7) == 0)
			return jidx_t'(15);
		return jidx_t'($urandom_range(0, JOINTS - 1));
	endfunction

	function automatic pos_t random_pos();
		case ($urandom_range(0, 9))
			0: return pos_t'(-32768);
			1: return pos_t'(32767);
			default: return pos_t'($urandom);
		endcase
	endfunction

	// The valid line is only lowered when a gap is drawn, so back-to-back
	// transactions keep it high.
	task automatic send_item(input logic op_v, input jidx_t idx, input pos_t sp,
			input pos_t tp);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		op              <= op_v;
		joint_index     <= idx;
		start_position  <= sp;
		target_position <= tp;
		do @(posedge clk); while (in_stall);
		apply_item(op_v, idx, sp, tp);
	endtask

	task automatic send_tick();
		send_item(OP_TICK, jidx_t'($urandom), pos_t'($urandom), pos_t'($urandom));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_duration(input dur_t value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		duration = value;
		cfg_valid <= 1'b0;
	endtask

	// Ticks on the reset tables and the reset duration.
	task automatic test_reset_state();
		send_tick();
		send_tick();
	endtask

	// Full-scale moves in both directions, run past the end of the motion.
	task automatic test_extremes();
		write_duration(dur_t'(4));
		send_item(OP_LOAD, jidx_t'(0), pos_t'(-32768), pos_t'(32767));
		send_item(OP_LOAD, jidx_t'(1), pos_t'(32767), pos_t'(-32768));
		send_item(OP_LOAD, jidx_t'(14), pos_t'(-1), pos_t'(1));
		send_item(OP_LOAD, jidx_t'(7), pos_t'(12345), pos_t'(12345));
		repeat (6) send_tick();
	endtask

	// A load to a joint that does not exist still restarts time.
	task automatic test_bad_index();
		send_item(OP_LOAD, jidx_t'(15), pos_t'(32767), pos_t'(-32768));
		send_tick();
		send_tick();
	endtask

	task automatic test_zero_duration();
		write_duration(dur_t'(0));
		send_item(OP_LOAD, jidx_t'(3), pos_t'(-5000), pos_t'(9000));
		send_tick();
		send_tick();
	endtask

	// Shortening the duration mid-motion clamps the tick count to it.
	task automatic test_duration_change();
		write_duration(dur_t'(8));
		send_item(OP_LOAD, jidx_t'(2), pos_t'(-20000), pos_t'(20000));
		repeat (3) send_tick();
		write_duration(dur_t'(2));
		send_tick();
		send_tick();
	endtask

	// The receiver holds off for a long stretch while ticks keep coming.
	task automatic test_backpressure();
		write_duration(dur_t'(10));
		sink_hold = HOLD_CYCLES;
		quiet = 1'b1;
		repeat (12) send_tick();
		quiet = 1'b0;
	endtask

	// Mostly a few loads followed by a run of ticks, with some noise mixed in.
	task automatic test_random_motion(input dur_t dur, input int items);
		int sent;
		int burst;
		int span;
		sent = 0;
		write_duration(dur);
		span = (dur > 30) ? 30 : int'(dur) + 3;
		while (sent < items) begin
			repeat ($urandom_range(1, 4)) begin
				send_item(OP_LOAD, random_joint(), random_pos(), random_pos());
				sent++;
			end
			burst = $urandom_range(1, span);
			repeat (burst) begin
				send_tick();
				sent++;
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					send_item(logic'($urandom), random_joint(), random_pos(), random_pos());
					sent++;
				end
			end
		end
	endtask

	initial begin : result_sink
		int wait_cycles;
		out_stall <= 1'b0;
		forever begin
			if (sink_hold > 0) begin
				out_stall <= 1'b1;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			wait_cycles = quiet ? 0 : $urandom_range(0, 4);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall) && sink_hold == 0);
		end
	end

	initial begin : result_check
		traj_result_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual joint %0d position %0d",
						$time, joint_out, command_position);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (joint_out !== want.joint) begin
						$display("%0t joint_out: expected %0d, actual %0d",
							$time, want.joint, joint_out);
						fail_count++;
					end
					if (command_position !== want.pos) begin
						$display("%0t command_position (joint %0d): expected %0d, actual %0d",
							$time, want.joint, want.pos, command_position);
						fail_count++;
					end
					if (last !== want.last) begin
						$display("%0t last (joint %0d): expected %0b, actual %0b",
							$time, want.joint, want.last, last);
						fail_count++;
					end
					if (done_res !== want.done) begin
						$display("%0t done_res (joint %0d): expected %0b, actual %0b",
							$time, want.joint, want.done, done_res);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		for (int j = 0; j < JOINTS; j++) begin
			start_tab[j]  = '0;
			target_tab[j] = '0;
		end
		tick_cnt   = 0;
		duration   = DUR_RESET;
		fail_count = 0;
		sink_hold  = 0;
		quiet      = 1'b0;

		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		op              <= OP_LOAD;
		joint_index     <= '0;
		start_position  <= '0;
		target_position <= '0;
		cfg_valid       <= 1'b0;
		cfg_data        <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_extremes();
		test_bad_index();
		test_zero_duration();
		test_duration_change();
		test_backpressure();
		test_random_motion(dur_t'(1), 30);
		test_random_motion(dur_t'(65535), 30);
		quiet = 1'b1;
		test_random_motion(dur_t'($urandom_range(2, 40)), 30);
		quiet = 1'b0;
		test_random_motion(dur_t'($urandom_range(3, 200)), 30);

		wait_idle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
